// ----- rtl/core/pre_pkg.sv -----
// pre_pkg: constants, handshake structs and helpers for the printable run extractor.
// Used by the interfaces, controller, datapath and top level. No dependencies.
`default_nettype none

package pre_pkg;

	localparam int MAX_RUN   = 4095;
	localparam int MAX_MIN   = 32;
	localparam int BYTE_W    = 8;
	localparam int RUN_W     = 12;
	localparam int MIN_W     = 6;
	localparam int IDX_W     = $clog2(MAX_MIN);
	localparam int MIN_RESET = 4;

	localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
	localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;
	localparam logic [BYTE_W-1:0] TAB_CHAR = 8'd9;
	localparam logic [BYTE_W-1:0] NEWLINE  = 8'd10;

	// controller -> datapath
	typedef struct packed {
		logic take;        // input transfer this cycle
		logic rd;          // read prefix entry at idx
		logic put_prefix;  // load output register from prefix read data
		logic put_final;   // load output register with pending byte, last set
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic emit;        // item being taken produces results
		logic flush;       // ... and starts with a prefix flush
		logic flush_done;  // current prefix index is the last held entry
	} sts_t;

	function automatic logic is_text_byte(input logic [BYTE_W-1:0] b);
		return ((b >= PRINT_LO) && (b <= PRINT_HI)) || (b == TAB_CHAR);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pre_if.sv -----
// pre_if: valid/ready channel interfaces for scan input, result output and config.
// Depends on pre_pkg for field widths.
`default_nettype none

interface pre_in_if;
	logic                           valid;
	logic                           ready;
	logic [pre_pkg::BYTE_W-1:0]     data_byte;
	logic                           end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface pre_out_if;
	logic                           valid;
	logic                           ready;
	logic [pre_pkg::BYTE_W-1:0]     out_byte;
	logic                           last_of_burst;

	modport source (output valid, output out_byte, output last_of_burst, input ready);
	modport sink   (input valid, input out_byte, input last_of_burst, output ready);
endinterface

interface pre_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pre_pkg::MIN_W-1:0]      min_run_length;

	modport source (output valid, output min_run_length, input ready);
	modport sink   (input valid, input min_run_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/printable_run_extractor_top.sv -----
// printable_run_extractor_top: top level, joins controller and datapath to the channels.
// Depends on pre_pkg, pre_if, pre_ctrl, pre_dp, pre_ram.
//
// Usage:
//  scan   : input channel, one stream byte per transfer, or an end_of_stream marker
//           (byte ignored) that closes the current run.
//  result : output channel, printable bytes of qualifying runs plus a newline (10)
//           closing each emitted run; last_of_burst marks the final result of an item.
//  cfg    : write channel for min_run_length, always ready; value 0 becomes 1 and
//           values above 32 become 32. Write only while the block is idle.
// Runs shorter than the minimum produce nothing; bytes past 4095 in one run are
// dropped. The first bytes of a run sit in a 32-entry prefix RAM until the run
// qualifies, then go out as one burst followed by the qualifying byte or a closing newline.
// Steps: an item without results is only accepted; one with a single result is
// accepted, then loaded into the output register. A prefix flush adds, for each
// held byte, a RAM read of its entry and then a load into the output register.
// scan.ready is high only while the controller waits for an item, so a new item is
// taken while the last result still sits in the output register.
// A stalled receiver holds the output register and freezes the sequence.
// Reset: minimum returns to 4, run state clears, output valid drops; prefix RAM is
// not cleared, only entries written in the current run are ever read.
`default_nettype none

module printable_run_extractor_top (
	input  wire logic clk,
	input  wire logic arst_n,
	pre_in_if.sink    scan,
	pre_out_if.source result,
	pre_cfg_if.sink   cfg
);

	pre_pkg::cmd_t cmd;
	pre_pkg::sts_t sts;

	// config writes need no arbitration
	assign cfg.ready = 1'b1;

	pre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scan.valid),
		.in_ready  (scan.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pre_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (scan.data_byte),
		.end_of_stream (scan.end_of_stream),
		.cfg_valid     (cfg.valid),
		.cfg_data      (cfg.min_run_length),
		.cmd           (cmd),
		.sts           (sts),
		.out_byte      (result.out_byte),
		.out_last      (result.last_of_burst)
	);

endmodule

`default_nettype wire

// ----- rtl/core/pre_ram.sv -----
// pre_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pre_ctrl.sv -----
// pre_ctrl: sequencing FSM and output valid register for the printable run extractor.
// Depends on pre_pkg (cmd_t, sts_t).
`default_nettype none

module pre_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	output      logic          out_valid,
	input  wire logic          out_ready,
	output      pre_pkg::cmd_t cmd,
	input  wire pre_pkg::sts_t sts
);

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_PUT, ST_LAST} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.take       = in_valid;
			ST_RD:   cmd.rd         = 1'b1;
			ST_PUT:  cmd.put_prefix = slot_free;
			ST_LAST: cmd.put_final  = slot_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.put_prefix || cmd.put_final) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take && sts.emit) begin
						state_q <= sts.flush ? ST_RD : ST_LAST;
					end
				end
				ST_RD: state_q <= ST_PUT;
				ST_PUT: begin
					if (slot_free) begin
						state_q <= sts.flush_done ? ST_LAST : ST_RD;
					end
				end
				ST_LAST: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pre_dp.sv -----
// pre_dp: run state, minimum register, prefix store and output payload register.
// Depends on pre_pkg and pre_ram.
`default_nettype none

module pre_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [pre_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic                         end_of_stream,
	input  wire logic                         cfg_valid,
	input  wire logic [pre_pkg::MIN_W-1:0]    cfg_data,
	input  wire pre_pkg::cmd_t                cmd,
	output      pre_pkg::sts_t                sts,
	output      logic [pre_pkg::BYTE_W-1:0]   out_byte,
	output      logic                         out_last
);

	logic [pre_pkg::MIN_W-1:0]  min_q;
	logic [pre_pkg::RUN_W-1:0]  run_q;
	logic                       flushed_q;
	logic [pre_pkg::IDX_W-1:0]  idx_q;
	logic [pre_pkg::IDX_W-1:0]  last_idx_q;
	logic [pre_pkg::BYTE_W-1:0] pend_q;
	logic [pre_pkg::BYTE_W-1:0] out_byte_q;
	logic                       out_last_q;
	logic [pre_pkg::BYTE_W-1:0] ram_rdata;
	logic [pre_pkg::MIN_W-1:0]  min_clamped;

	logic prt, run_ok, reach, run_nz, at_min;
	logic p_emit, p_store, p_flush, e_emit, e_flush, ram_we;

	always_comb begin
		prt    = !end_of_stream && pre_pkg::is_text_byte(data_byte);
		run_ok = run_q < pre_pkg::RUN_W'(pre_pkg::MAX_RUN);
		reach  = ({1'b0, run_q} + 1'b1) >= (pre_pkg::RUN_W + 1)'(min_q);
		run_nz = (run_q != '0);
		at_min = run_q >= pre_pkg::RUN_W'(min_q);

		p_emit  = run_ok && (flushed_q || reach);
		p_flush = run_ok && !flushed_q && reach && run_nz;
		p_store = run_ok && !flushed_q && !reach;
		e_emit  = flushed_q || (at_min && run_nz);
		e_flush = !flushed_q && at_min && run_nz;

		sts.emit       = prt ? p_emit : e_emit;
		sts.flush      = prt ? p_flush : e_flush;
		sts.flush_done = (idx_q == last_idx_q);
		ram_we         = cmd.take && prt && p_store;
	end

	// clamp written minimum to 1..MAX_MIN
	always_comb begin
		priority if (cfg_data == '0) begin
			min_clamped = pre_pkg::MIN_W'(1);
		end else if (cfg_data > pre_pkg::MIN_W'(pre_pkg::MAX_MIN)) begin
			min_clamped = pre_pkg::MIN_W'(pre_pkg::MAX_MIN);
		end else begin
			min_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= pre_pkg::MIN_W'(pre_pkg::MIN_RESET);
			run_q     <= '0;
			flushed_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				min_q <= min_clamped;
			end
			if (cmd.take) begin
				if (prt) begin
					if (p_emit) begin
						run_q     <= run_q + 1'b1;
						flushed_q <= 1'b1;
					end else if (p_store) begin
						run_q <= run_q + 1'b1;
					end
				end else begin
					run_q     <= '0;
					flushed_q <= 1'b0;
				end
			end
		end
	end

	// payload and sequencing registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pend_q     <= prt ? data_byte : pre_pkg::NEWLINE;
			idx_q      <= '0;
			last_idx_q <= run_q[pre_pkg::IDX_W-1:0] - 1'b1;
		end
		if (cmd.put_prefix) begin
			out_byte_q <= ram_rdata;
			out_last_q <= 1'b0;
			idx_q      <= idx_q + 1'b1;
		end else if (cmd.put_final) begin
			out_byte_q <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	pre_ram #(
		.WIDTH(pre_pkg::BYTE_W),
		.DEPTH(pre_pkg::MAX_MIN)
	) u_prefix (
		.clk   (clk),
		.we    (ram_we),
		.waddr (run_q[pre_pkg::IDX_W-1:0]),
		.wdata (data_byte),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/core/pre_checker.sv -----
// pre_checker: port-level assertions for printable_run_extractor_top, plus its bind.
// Depends on pre_pkg.
`default_nettype none

module pre_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       scan_ready,
	input wire logic                       res_valid,
	input wire logic                       res_ready,
	input wire logic [pre_pkg::BYTE_W-1:0] res_byte,
	input wire logic                       res_last
);

	// held result stays put while stalled
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_last))
		else $error("result changed while stalled");

	// a newline only ever closes a burst
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_byte == pre_pkg::NEWLINE) |-> res_last)
		else $error("newline not marked last");

	// every emitted byte is printable or the closing newline
	a_res_char: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pre_pkg::is_text_byte(res_byte) || (res_byte == pre_pkg::NEWLINE))
		else $error("non-printable byte emitted");

	// no new item is taken while a burst is still open
	a_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |-> !scan_ready)
		else $error("input ready during open burst");

endmodule

bind printable_run_extractor_top pre_checker u_pre_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.scan_ready (scan.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_byte   (result.out_byte),
	.res_last   (result.last_of_burst)
);

`default_nettype wire

// ----- tb/printable_run_extractor_top_tb.sv -----
// printable_run_extractor_top_tb: self-checking bench for the printable run extractor.
// Drives the scan, result and cfg channels through pre_if, predicts every result byte
// in a small scoreboard class. Depends on pre_pkg, pre_if and the RTL top level.
`timescale 1ns / 100ps

module printable_run_extractor_top_tb;

	// one expected or observed result transfer
	typedef struct packed {
		logic [pre_pkg::BYTE_W-1:0] out_byte;
		logic                       last_of_burst;
	} run_beat_t;

	// Scoreboard: tracks the run state of the extractor, turns every accepted scan
	// transfer into the result bytes it must cause and checks them in order.
	class extract_scoreboard;
		logic [pre_pkg::MIN_W-1:0]  min_len;
		logic [pre_pkg::RUN_W-1:0]  run_len;
		logic [pre_pkg::BYTE_W-1:0] held [pre_pkg::MAX_MIN];
		bit                         emitted;
		run_beat_t                  out_fifo [$];
		int                         mismatch_count;

		function new();
			min_len        = pre_pkg::MIN_W'(pre_pkg::MIN_RESET);
			run_len        = '0;
			emitted        = 1'b0;
			mismatch_count = 0;
		endfunction

		// register write: 0 reads as 1, anything above MAX_MIN saturates
		function void set_min(logic [pre_pkg::MIN_W-1:0] v);
			if (v == '0)
				min_len = pre_pkg::MIN_W'(1);
			else if (int'(v) > pre_pkg::MAX_MIN)
				min_len = pre_pkg::MIN_W'(pre_pkg::MAX_MIN);
			else
				min_len = v;
		endfunction

		function void push_beat(logic [pre_pkg::BYTE_W-1:0] b);
			out_fifo.push_back('{out_byte: b, last_of_burst: 1'b0});
		endfunction

		function void flush_held();
			for (int i = 0; i < int'(run_len) && i < pre_pkg::MAX_MIN; i++)
				push_beat(held[i]);
		endfunction

		// accepted scan transfer -> expected result bytes
		function void note_scan(logic [pre_pkg::BYTE_W-1:0] b, logic eos);
			int        start_cnt;
			run_beat_t tail;
			start_cnt = out_fifo.size();
			if (!eos && ((b >= pre_pkg::PRINT_LO && b <= pre_pkg::PRINT_HI) ||
					b == pre_pkg::TAB_CHAR)) begin
				// past the run limit printable bytes are dropped silently
				if (int'(run_len) < pre_pkg::MAX_RUN) begin
					if (emitted) begin
						push_beat(b);
					end else if (int'(run_len) + 1 >= int'(min_len)) begin
						flush_held();
						push_beat(b);
						emitted = 1'b1;
					end else begin
						held[run_len[pre_pkg::IDX_W-1:0]] = b;
					end
					run_len = run_len + 1'b1;
				end
			end else begin
				if (emitted) begin
					push_beat(pre_pkg::NEWLINE);
				end else if (run_len != 0 && int'(run_len) >= int'(min_len)) begin
					flush_held();
					push_beat(pre_pkg::NEWLINE);
				end
				run_len = '0;
				emitted = 1'b0;
			end
			if (out_fifo.size() > start_cnt) begin
				tail = out_fifo.pop_back();
				tail.last_of_burst = 1'b1;
				out_fifo.push_back(tail);
			end
		endfunction

		function void flag(string what, run_beat_t want, run_beat_t got);
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s: expected byte %0d last %0b, got byte %0d last %0b",
					$realtime, what, want.out_byte, want.last_of_burst,
					got.out_byte, got.last_of_burst);
		endfunction

		function void check_result(logic [pre_pkg::BYTE_W-1:0] b, logic last);
			run_beat_t want;
			run_beat_t got;
			got = '{out_byte: b, last_of_burst: last};
			if (out_fifo.size() == 0) begin
				flag("result with nothing pending", '0, got);
				return;
			end
			want = out_fifo.pop_front();
			if (want.out_byte !== got.out_byte || want.last_of_burst !== got.last_of_burst)
				flag("result mismatch", want, got);
		endfunction

		function int pending();
			return out_fifo.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pre_in_if  scan_if ();
	pre_out_if result_if ();
	pre_cfg_if cfg_if ();

	extract_scoreboard sb;

	// burst flags: while set, that side takes no idle cycles at all
	bit scan_burst;
	bit sink_burst;

	printable_run_extractor_top u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.scan  (scan_if),
		.result(result_if),
		.cfg   (cfg_if)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop in case the block hangs; several times the slowest legal run
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [pre_pkg::BYTE_W-1:0] rand_printable();
		if ($urandom_range(0, 9) == 0)
			return pre_pkg::TAB_CHAR;
		return pre_pkg::BYTE_W'($urandom_range(int'(pre_pkg::PRINT_LO),
			int'(pre_pkg::PRINT_HI)));
	endfunction

	// a byte that ends a run: control codes, newline, DEL and the high half
	function automatic logic [pre_pkg::BYTE_W-1:0] rand_control();
		case ($urandom_range(0, 2))
			0: return pre_pkg::BYTE_W'($urandom_range(0, 8));
			1: return pre_pkg::BYTE_W'($urandom_range(10, 31));
			default: return pre_pkg::BYTE_W'($urandom_range(127, 255));
		endcase
	endfunction

	// one scan transfer, after a random idle gap unless scan_burst is set
	task automatic send_scan(logic [pre_pkg::BYTE_W-1:0] b, logic eos);
		int gap;
		if ($urandom_range(0, 31) == 0)
			scan_burst = !scan_burst;
		gap = scan_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			scan_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		scan_if.data_byte     <= b;
		scan_if.end_of_stream <= eos;
		scan_if.valid         <= 1'b1;
		do @(posedge clk); while (!scan_if.ready);
		sb.note_scan(b, eos);
	endtask

	// Wait until every predicted byte has come out, then a few more cycles since
	// an item without results may still be in flight. Bounded so that a lost
	// result ends up as a leftover expectation instead of a hang.
	task automatic wait_drained();
		int guard;
		guard = 0;
		scan_if.valid <= 1'b0;
		while (sb.pending() != 0 && guard < 4000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	// cfg write; only called once the block has drained
	task automatic write_min(logic [pre_pkg::MIN_W-1:0] v);
		cfg_if.min_run_length <= v;
		cfg_if.valid          <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		sb.set_min(v);
		@(posedge clk);
	endtask

	// Result side: random stall before each transfer, with stretches where ready
	// simply stays high.
	initial begin : result_sink
		int stall;
		result_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				sink_burst = !sink_burst;
			stall = sink_burst ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!(result_if.valid && result_if.ready));
			sb.check_result(result_if.out_byte, result_if.last_of_burst);
		end
	end

	initial begin : stimulus
		int                         phase_min [8];
		int                         sent;
		int                         len;
		int                         lo;
		int                         retune;
		logic [pre_pkg::BYTE_W-1:0] text;

		sb         = new();
		scan_burst = 1'b0;
		sink_burst = 1'b0;

		arst_n                <= 1'b0;
		scan_if.valid         <= 1'b0;
		scan_if.data_byte     <= '0;
		scan_if.end_of_stream <= 1'b0;
		cfg_if.valid          <= 1'b0;
		cfg_if.min_run_length <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, reset minimum of 4 ----
		// short run closed by the end marker: nothing comes out
		send_scan("a", 1'b0);
		send_scan("b", 1'b0);
		send_scan("c", 1'b0);
		send_scan(8'hFF, 1'b1);
		// end marker with no run open
		send_scan(8'h00, 1'b1);
		// printable range edges and tab; fourth byte qualifies the run,
		// DEL just above the range closes it with a newline
		send_scan(pre_pkg::PRINT_LO, 1'b0);
		send_scan(pre_pkg::PRINT_HI, 1'b0);
		send_scan(pre_pkg::TAB_CHAR, 1'b0);
		send_scan("A", 1'b0);
		send_scan(8'd127, 1'b0);
		// non-printables around the edges, newline byte as input
		send_scan(8'd0, 1'b0);
		send_scan(8'd255, 1'b0);
		send_scan(8'd31, 1'b0);
		send_scan(8'd8, 1'b0);
		send_scan(pre_pkg::NEWLINE, 1'b0);
		wait_drained();

		// zero written reads as a minimum of 1: single byte run is emitted
		write_min(6'd0);
		send_scan("Q", 1'b0);
		send_scan(8'h00, 1'b1);
		wait_drained();

		// all-ones saturates to MAX_MIN; then lower the minimum mid-run so the
		// next byte flushes the held prefix, then raise it after emission
		write_min(6'd63);
		for (int i = 0; i < 5; i++)
			send_scan(rand_printable(), 1'b0);
		wait_drained();
		write_min(6'd3);
		send_scan("z", 1'b0);
		wait_drained();
		write_min(6'd32);
		send_scan("y", 1'b0);
		send_scan("x", 1'b0);
		send_scan(8'h00, 1'b1);
		wait_drained();

		// minimum lowered mid-run, then the run ends: prefix plus newline
		for (int i = 0; i < 6; i++)
			send_scan(rand_printable(), 1'b0);
		wait_drained();
		write_min(6'd33);
		write_min(6'd4);
		send_scan(8'h55, 1'b1);
		wait_drained();

		// ---- random part: mostly well-formed runs around the minimum ----
		phase_min = '{1, 63, 2, 32, 0, 5, 17, 33};
		phase_min[5] = $urandom_range(0, 63);
		phase_min[6] = $urandom_range(0, 63);
		for (int p = 0; p < 8; p++) begin
			write_min(pre_pkg::MIN_W'(phase_min[p]));
			sent = 0;
			while (sent < 30) begin
				if ($urandom_range(0, 9) < 8) begin
					// run lengths cluster near the threshold, some go well past it
					lo = (int'(sb.min_len) > 2) ? int'(sb.min_len) - 2 : 0;
					if ($urandom_range(0, 3) == 0)
						len = $urandom_range(0, 2 * int'(sb.min_len) + 4);
					else
						len = $urandom_range(lo, int'(sb.min_len) + 6);
					// occasionally retune the minimum in the middle of the run
					retune = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : -1;
					for (int k = 0; k < len; k++) begin
						if (k == retune) begin
							wait_drained();
							write_min(pre_pkg::MIN_W'($urandom_range(0, 63)));
						end
						send_scan(rand_printable(), 1'b0);
						sent++;
					end
					if ($urandom_range(0, 1) == 0)
						send_scan(rand_control(), 1'b0);
					else
						send_scan(pre_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
					sent++;
				end else begin
					// noise: any byte, sometimes an end marker
					text = pre_pkg::BYTE_W'($urandom_range(0, 255));
					send_scan(text, $urandom_range(0, 3) == 0);
					sent++;
				end
			end
			// close whatever run is open before the next setting
			send_scan(8'h00, 1'b1);
			wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			if (sb.pending() != 0)
				$display("%0d expected results never arrived", sb.pending());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
